@@ hdl/pws_pkg.sv @@
package pws_pkg;

  // Number of intervals in the tanh table; the table holds one more entry.
  localparam int TANH_TABLE_ENTRIES = 256;
  localparam int TAB_IDX_W = $clog2(TANH_TABLE_ENTRIES + 1);
  localparam int SEG_W     = $clog2(TANH_TABLE_ENTRIES);
  localparam int FRAC_W    = 26;
  localparam int POS_W     = FRAC_W + SEG_W;

  localparam int SAMPLE_W = 24;
  localparam int LEVEL_W  = 23;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 2;

  // Shared multiply-accumulate unit widths.
  localparam int MAC_OP_W  = 28;
  localparam int MAC_ACC_W = 58;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_RAW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 2'd2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [23:0] ONE_Q23 = 24'd8388608;
  localparam logic [22:0] MAX_Q23 = 23'd8388607;
  localparam logic [16:0] KNEE_Q16 = 17'd39322;
  localparam logic [15:0] KNEE_OUT_Q16 = 16'd19661;
  localparam logic [15:0] MIN_CURVE = 16'd66;
  localparam logic [15:0] K_0P3_Q16 = 16'd19661;
  localparam logic [15:0] K_0P7_Q16 = 16'd45875;

  typedef struct packed {
    logic en;
    logic clr;
  } pws_mac_ctrl_t;

  typedef logic [22:0] tanh_tab_t [0:TANH_TABLE_ENTRIES];

  // Unsigned restoring long division, used only while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] dividend, logic [63:0] divisor);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], dividend[b]};
      if (rem >= {1'b0, divisor}) begin
        rem = rem - {1'b0, divisor};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry i holds tanh(8i/N) in Q0.23, built from a truncated exp series in Q30.
  // The 64-bit products wrap exactly as the unsigned arithmetic they mirror.
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t tab;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] prod;
    logic signed [63:0] sum;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] v;
    for (int i = 0; i <= TANH_TABLE_ENTRIES; i++) begin
      z = udiv64(64'(i) << 30, 64'(TANH_TABLE_ENTRIES));
      term = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int n = 1; n <= 16; n++) begin
        prod = term * z;
        term = udiv64(prod >> 30, 64'(n));
        if (n[0] == 1'b1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      if (sum > (64'sd1 <<< 30)) begin
        sum = 64'sd1 <<< 30;
      end
      e = $unsigned(sum);
      for (int k = 0; k < 4; k++) begin
        e = (e * e) >> 30;
      end
      num = ((64'd1 << 30) - e) << 23;
      den = (64'd1 << 30) + e;
      v = udiv64(num + (den >> 1), den);
      if (v > 64'(MAX_Q23)) begin
        v = 64'(MAX_Q23);
      end
      tab[i] = v[22:0];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

@@ hdl/pws_if.sv @@
interface pws_in_if;
  import pws_pkg::*;
  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface pws_out_if;
  import pws_pkg::*;
  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [LEVEL_W-1:0] envelope;
  modport source (output valid, output sample_out, output envelope, input ready);
  modport sink (input valid, input sample_out, input envelope, output ready);
endinterface

@@ hdl/pressure_waveshaper_with_follower.sv @@
// Pressure waveshaper with level follower. Each sample item updates an
// attack/release follower of the sample magnitude, then drives the sample,
// shapes it with an interpolated tanh term and a square term mixed by the
// curved pressure, and blends the result with the dry sample by the curved
// pressure times twice the level, clamped. Below the pass-through threshold
// the follower still updates and the sample goes out unchanged. Every
// product goes through a single shared multiply-accumulate unit stepped by
// a sequencer; the input is not ready until the previous result has been
// taken. Configuration may be written only while the block is idle.
module pressure_waveshaper_with_follower import pws_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  pws_in_if.sink               in_if,
  pws_out_if.source            out_if
);

  // Sequencer steps. Each step issues at most one product to the MAC and may
  // consume the product issued by the step before it.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_COEF  = 5'd1;
  localparam logic [4:0] S_LEVEL = 5'd2;
  localparam logic [4:0] S_D     = 5'd3;
  localparam logic [4:0] S_T     = 5'd4;
  localparam logic [4:0] S_EVEN  = 5'd5;
  localparam logic [4:0] S_POS   = 5'd6;
  localparam logic [4:0] S_H     = 5'd7;
  localparam logic [4:0] S_E     = 5'd8;
  localparam logic [4:0] S_ODD   = 5'd9;
  localparam logic [4:0] S_IN0   = 5'd10;
  localparam logic [4:0] S_IN1   = 5'd11;
  localparam logic [4:0] S_SH0   = 5'd12;
  localparam logic [4:0] S_SH1   = 5'd13;
  localparam logic [4:0] S_MAG0  = 5'd14;
  localparam logic [4:0] S_MAG1  = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [4:0] step_q, step_d;

  // Configuration registers.
  logic [16:0] pressure_q;
  logic [15:0] attack_q;
  logic [15:0] release_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressure_q <= '0;
      attack_q   <= 16'd328;
      release_q  <= 16'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRESSURE_RAW:  pressure_q <= cfg_data_i;
        REG_ATTACK_COEFF:  attack_q   <= cfg_data_i[15:0];
        REG_RELEASE_COEFF: release_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Pressure curve: slope 0.5 below the knee at 0.6, slope 1.75 above it.
  // Only configuration feeds it, so it is settled before any item arrives.
  logic [16:0] p_clamped;
  logic [17:0] knee_excess;
  logic [15:0] curve;

  assign p_clamped   = (pressure_q > ONE_Q16) ? ONE_Q16 : pressure_q;
  assign knee_excess = 18'(p_clamped - KNEE_Q16);

  always_comb begin
    if (p_clamped < KNEE_Q16) begin
      curve = p_clamped[16:1];
    end else begin
      curve = KNEE_OUT_Q16 + 16'((knee_excess * 18'd7) >> 2);
    end
  end

  // Item registers.
  logic                 in_acc;
  logic [SAMPLE_W-1:0]  raw_q;
  logic                 neg_q;
  logic [23:0]          mag_in_q;
  logic                 rise_q;
  logic [22:0]          diff_q;
  logic [LEVEL_W-1:0]   level_q;
  logic [24:0]          d_q;
  logic [25:0]          t_q;
  logic [26:0]          even_q;
  logic [POS_W-1:0]     pos_q;
  logic [14:0]          h_q;
  logic [22:0]          lo_q, hi_q;
  logic [16:0]          e_q;
  logic [22:0]          odd_q;
  logic [25:0]          inner_q;
  logic [26:0]          shaped_q;

  logic                 out_valid_q;
  logic [SAMPLE_W-1:0]  out_sample_q;

  logic [SAMPLE_W-1:0]  raw_in;
  logic [23:0]          mag_in;
  logic [22:0]          mag_clamped;

  assign in_acc = in_if.valid && in_if.ready;
  assign in_if.ready = (step_q == S_IDLE) && !out_valid_q;

  assign raw_in      = in_if.sample_in;
  assign mag_in      = raw_in[23] ? 24'(25'h1000000 - 25'(raw_in)) : raw_in;
  assign mag_clamped = (mag_in > 24'(MAX_Q23)) ? MAX_Q23 : mag_in[22:0];

  // Shared MAC.
  pws_mac_ctrl_t        mac_ctrl;
  logic [MAC_OP_W-1:0]  op_a, op_b;
  logic [MAC_ACC_W-1:0] acc;

  pws_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  logic [23:0]          lvl_sh;
  logic [23:0]          ls;
  logic [22:0]          slope;
  logic [TAB_IDX_W-1:0] seg;
  logic [MAC_ACC_W-1:0] mag_full;
  logic                 pass_through;

  assign lvl_sh = {level_q, 1'b0};
  assign ls     = (lvl_sh > ONE_Q23) ? ONE_Q23 : lvl_sh;
  assign slope  = (hi_q < lo_q) ? 23'd0 : (hi_q - lo_q);
  assign seg    = TAB_IDX_W'(pos_q[POS_W-1:FRAC_W]);
  assign mag_full = acc >> 16;
  assign pass_through = curve < MIN_CURVE;

  // Operand selection for the MAC.
  always_comb begin
    mac_ctrl = '{en: 1'b1, clr: 1'b1};
    op_a = '0;
    op_b = '0;
    case (step_q)
      S_COEF: begin
        op_a = MAC_OP_W'(rise_q ? attack_q : release_q);
        op_b = MAC_OP_W'(diff_q);
      end
      S_LEVEL: begin
        op_a = MAC_OP_W'(mag_in_q);
        op_b = MAC_OP_W'(18'(ONE_Q16) + {1'b0, curve, 1'b0});
      end
      S_D: begin
        // The driven magnitude is still in the accumulator in this step.
        op_a = MAC_OP_W'(acc >> 16);
        op_b = MAC_OP_W'(ONE_Q16 + 17'(curve));
      end
      S_T: begin
        op_a = MAC_OP_W'(d_q);
        op_b = MAC_OP_W'(d_q);
      end
      S_EVEN: begin
        op_a = MAC_OP_W'(t_q);
        op_b = MAC_OP_W'(TANH_TABLE_ENTRIES);
      end
      S_POS: begin
        op_a = MAC_OP_W'(curve);
        op_b = MAC_OP_W'(K_0P3_Q16);
      end
      S_H: begin
        op_a = MAC_OP_W'(curve);
        op_b = MAC_OP_W'(ls);
      end
      S_E: begin
        op_a = MAC_OP_W'(slope);
        op_b = MAC_OP_W'(pos_q[FRAC_W-1:0]);
      end
      S_IN0: begin
        op_a = MAC_OP_W'(odd_q);
        op_b = MAC_OP_W'(K_0P7_Q16);
      end
      S_IN1: begin
        mac_ctrl.clr = 1'b0;
        op_a = MAC_OP_W'(even_q);
        op_b = MAC_OP_W'(K_0P3_Q16);
      end
      S_SH0: begin
        op_a = MAC_OP_W'(odd_q);
        op_b = MAC_OP_W'(ONE_Q16 - 17'(h_q));
      end
      S_SH1: begin
        mac_ctrl.clr = 1'b0;
        op_a = MAC_OP_W'(inner_q);
        op_b = MAC_OP_W'(h_q);
      end
      S_MAG0: begin
        op_a = MAC_OP_W'(mag_in_q);
        op_b = MAC_OP_W'(ONE_Q16 - e_q);
      end
      S_MAG1: begin
        mac_ctrl.clr = 1'b0;
        op_a = MAC_OP_W'(shaped_q);
        op_b = MAC_OP_W'(e_q);
      end
      S_OUT: begin
        // Hold the accumulator while the final sum is read out.
        mac_ctrl.en = 1'b0;
      end
      default: begin
        mac_ctrl.en = 1'b0;
      end
    endcase
  end

  // Step sequencing.
  always_comb begin
    step_d = step_q;
    case (step_q)
      S_IDLE:  step_d = in_acc ? S_COEF : S_IDLE;
      S_D:     step_d = pass_through ? S_IDLE : S_T;
      S_OUT:   step_d = S_IDLE;
      default: step_d = step_q + 5'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (out_if.valid && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (step_q == S_LEVEL) begin
        if (rise_q) begin
          level_q <= level_q + LEVEL_W'(acc >> 16);
        end else begin
          level_q <= level_q - LEVEL_W'(acc >> 16);
        end
      end
      if ((step_q == S_D && pass_through) || step_q == S_OUT) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Datapath registers, loaded by the step that sees their product.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q    <= raw_in;
      neg_q    <= raw_in[23];
      mag_in_q <= mag_in;
      rise_q   <= mag_clamped > level_q;
      diff_q   <= (mag_clamped > level_q) ? (mag_clamped - level_q)
                                          : (level_q - mag_clamped);
    end
    case (step_q)
      S_D: begin
        d_q <= 25'(acc >> 16);
        if (pass_through) begin
          out_sample_q <= raw_q;
        end
      end
      S_T:    t_q    <= 26'(acc >> 16);
      S_EVEN: even_q <= 27'(acc >> 23);
      S_POS:  pos_q  <= POS_W'(acc);
      S_H: begin
        // The drive gain keeps t below 8.0, so the segment is always inside
        // the table and the next entry exists.
        h_q  <= 15'(acc >> 16);
        lo_q <= TANH_TAB[seg];
        hi_q <= TANH_TAB[seg + TAB_IDX_W'(1)];
      end
      S_E:    e_q     <= ((acc >> 23) > MAC_ACC_W'(ONE_Q16)) ? ONE_Q16 : 17'(acc >> 23);
      S_ODD:  odd_q   <= lo_q + 23'(acc >> FRAC_W);
      S_SH0:  inner_q <= 26'(acc >> 16);
      S_MAG0: shaped_q <= 27'(acc >> 16);
      S_OUT: begin
        // Saturate the magnitude, then restore the sign of the input.
        if (neg_q) begin
          if (mag_full > MAC_ACC_W'(ONE_Q23)) begin
            out_sample_q <= 24'h800000;
          end else begin
            out_sample_q <= 24'(25'h1000000 - 25'(mag_full));
          end
        end else begin
          if (mag_full > MAC_ACC_W'(MAX_Q23)) begin
            out_sample_q <= 24'(MAX_Q23);
          end else begin
            out_sample_q <= 24'(mag_full);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.sample_out = out_sample_q;
  assign out_if.envelope   = level_q;

endmodule

@@ hdl/pws_mac.sv @@
module pws_mac import pws_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pws_mac_ctrl_t        ctrl_i,
  input  logic [MAC_OP_W-1:0]  op_a_i,
  input  logic [MAC_OP_W-1:0]  op_b_i,
  output logic [MAC_ACC_W-1:0] acc_o
);

  logic [MAC_ACC_W-1:0] acc_q, acc_d;
  logic [2*MAC_OP_W-1:0] prod;

  assign prod = op_a_i * op_b_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.en) begin
      acc_d = (ctrl_i.clr ? '0 : acc_q) + MAC_ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ hdl/pws_checker.sv @@
module pws_checker import pws_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [SAMPLE_W-1:0] sample_out_i,
  input logic [LEVEL_W-1:0]  envelope_i
);

  // One item at a time: no new item while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i)
    else $error("input ready while a result is pending");

  // After an item is taken the input is not ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  // The envelope moves only with an accepted item, so it holds while a stalled result waits.
  a_env_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(envelope_i))
    else $error("envelope changed while a result waits");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(sample_out_i)))
    else $error("stalled result dropped or changed");

endmodule

bind pressure_waveshaper_with_follower pws_checker u_pws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .sample_out_i (out_if.sample_out),
  .envelope_i   (out_if.envelope)
);

@@ verif/tb_pressure_waveshaper_with_follower.sv @@
`timescale 1ns / 1ps

// Testbench for the pressure waveshaper with level follower.
// Sample items go in through the input channel. For each accepted item a
// predictor computes the shaped sample and the new follower level. The
// predictor keeps its own copy of the level and of the three registers.
// A checker process compares every result item with the oldest prediction.
module tb_pressure_waveshaper_with_follower;
  import pws_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  pws_in_if in_if ();
  pws_out_if out_if ();

  pressure_waveshaper_with_follower dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  // Predictor state. These mirror the registers and the level inside the block.
  logic [16:0] pressure_q;
  logic [15:0] attack_q;
  logic [15:0] release_q;
  logic [22:0] level_q;
  logic [22:0] tanh_ref [0:TANH_TABLE_ENTRIES];

  typedef struct packed {
    logic [23:0] sample;
    logic [22:0] env;
  } shaped_t;

  shaped_t shaped_pending [$];
  int errors;
  int results_seen;
  int items_sent;
  longint cycle_count;
  bit stall_enable;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The table is rebuilt here from the exp series, in 64-bit unsigned terms.
  task automatic make_tanh_ref();
    logic [63:0] z, term, e, num, den, v;
    logic signed [63:0] acc;
    for (int i = 0; i <= TANH_TABLE_ENTRIES; i++) begin
      z = (64'(i) << 30) / TANH_TABLE_ENTRIES;
      term = 64'd1 << 30;
      acc = 64'sd1 << 30;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * z) >> 30) / 64'(n);
        if (n % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
      e = acc;
      for (int k = 0; k < 4; k++) e = (e * e) >> 30;
      num = ((64'd1 << 30) - e) << 23;
      den = (64'd1 << 30) + e;
      v = (num + den / 2) / den;
      if (v > 64'd8388607) v = 64'd8388607;
      tanh_ref[i] = v[22:0];
    end
  endtask

  function automatic logic [63:0] tanh_interp(logic [63:0] t);
    logic [63:0] pos, idx, frac, lo, hi;
    if (t >= (64'd1 << 26)) return 64'(tanh_ref[TANH_TABLE_ENTRIES]);
    pos = t * TANH_TABLE_ENTRIES;
    idx = pos >> 26;
    frac = pos & ((64'd1 << 26) - 1);
    if (idx >= TANH_TABLE_ENTRIES) return 64'(tanh_ref[TANH_TABLE_ENTRIES]);
    lo = tanh_ref[idx];
    hi = tanh_ref[idx + 1];
    if (hi < lo) return lo;
    return lo + (((hi - lo) * frac) >> 26);
  endfunction

  // Advances the follower and returns the shaped sample with the new level.
  function automatic shaped_t shape_sample(logic [23:0] x);
    logic neg;
    logic [63:0] a, m, c, p, lv, d, t, odd, even, h, inner, shp, ls, e, mag, res;
    shaped_t r;
    neg = x[23];
    a = neg ? (64'h1000000 - 64'(x)) : 64'(x);
    m = (a > 64'd8388607) ? 64'd8388607 : a;
    lv = level_q;
    if (m > lv) lv = lv + ((64'(attack_q) * (m - lv)) >> 16);
    else lv = lv - ((64'(release_q) * (lv - m)) >> 16);
    lv = lv & 64'h7FFFFF;
    level_q = lv[22:0];
    p = (pressure_q > 17'd65536) ? 64'd65536 : 64'(pressure_q);
    c = (p < 64'd39322) ? (p >> 1) : (64'd19661 + ((64'd7 * (p - 64'd39322)) >> 2));
    if (c < 64'd66) begin
      res = 64'(x);
    end else begin
      d = (a * (64'd65536 + 2 * c)) >> 16;
      t = (d * (64'd65536 + c)) >> 16;
      odd = tanh_interp(t);
      even = (d * d) >> 23;
      h = (c * 64'd19661) >> 16;
      inner = (odd * 64'd45875 + even * 64'd19661) >> 16;
      shp = (odd * (64'd65536 - h) + inner * h) >> 16;
      ls = 2 * lv;
      if (ls > 64'd8388608) ls = 64'd8388608;
      e = (c * ls) >> 23;
      if (e > 64'd65536) e = 64'd65536;
      mag = (a * (64'd65536 - e) + shp * e) >> 16;
      if (neg) begin
        if (mag > 64'd8388608) mag = 64'd8388608;
        res = (64'h1000000 - mag) & 64'hFFFFFF;
      end else begin
        if (mag > 64'd8388607) mag = 64'd8388607;
        res = mag;
      end
    end
    r.sample = res[23:0];
    r.env = lv[22:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_sample(logic [23:0] x);
    int gap;
    gap = stall_enable ? pick_gap() : 0;
    repeat (gap) @(posedge clk_i);
    in_if.valid <= 1'b1;
    in_if.sample_in <= x;
    do @(posedge clk_i); while (!in_if.ready);
    // The item is accepted at this edge; predict it right away.
    shaped_pending.push_back(shape_sample(x));
    items_sent++;
    in_if.valid <= 1'b0;
    // The block is busy after an accepted item, so this edge costs nothing.
    @(posedge clk_i);
  endtask

  // Waits for the block to drain before a register is touched.
  task automatic wait_drained();
    while (shaped_pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PRESSURE_RAW: pressure_q = data;
      REG_ATTACK_COEFF: attack_q = data[15:0];
      REG_RELEASE_COEFF: release_q = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_all(logic [16:0] p, logic [15:0] att, logic [15:0] rel);
    wait_drained();
    write_reg(REG_PRESSURE_RAW, p);
    write_reg(REG_ATTACK_COEFF, 17'(att));
    write_reg(REG_RELEASE_COEFF, 17'(rel));
  endtask

  // Samples biased toward the extremes and toward small values.
  function automatic logic [23:0] rand_sample();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 24'h800000;
    if (roll == 1) return 24'h7FFFFF;
    if (roll < 4) return 24'($signed($urandom_range(0, 2047)) - 1024);
    return 24'($urandom);
  endfunction

  // Directed: reset settings, field extremes, every special case.
  task automatic test_directed();
    logic [23:0] edges [7];
    edges = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
              24'h400000, 24'hC00000};
    // Reset pressure is zero: pass-through while the follower still moves.
    foreach (edges[i]) send_sample(edges[i]);
    // Pressure above 1.0 is clamped; fast attack gives a large envelope.
    set_all(17'h1FFFF, 16'hFFFF, 16'hFFFF);
    foreach (edges[i]) send_sample(edges[i]);
    // Just below and at the knee, and at the pass-through threshold edge.
    set_all(17'd131, 16'd328, 16'd7);
    send_sample(24'h7FFFFF);
    set_all(17'd132, 16'd0, 16'd0);
    send_sample(24'h123456);
    set_all(17'd39321, 16'd20000, 16'd100);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    set_all(17'd39322, 16'd20000, 16'd100);
    send_sample(24'h000100);
    set_all(17'd65536, 16'd328, 16'd7);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
  endtask

  // Random: each phase draws new registers, then a burst of random samples.
  task automatic test_random();
    logic [16:0] p;
    for (int ph = 0; ph < 27; ph++) begin
      case ($urandom_range(0, 3))
        0: p = 17'($urandom_range(0, 140));
        1: p = 17'($urandom_range(65536, 131071));
        default: p = 17'($urandom_range(0, 65536));
      endcase
      set_all(p, 16'($urandom), ($urandom_range(0, 1)) ? 16'($urandom_range(0, 64))
                                                      : 16'($urandom));
      stall_enable = (ph % 5) != 3;
      for (int k = 0; k < 50; k++) send_sample(rand_sample());
    end
    stall_enable = 1'b1;
  endtask

  // The sender holds off until every prediction has been matched.
  task automatic test_drain_pause();
    for (int k = 0; k < 10; k++) begin
      send_sample(rand_sample());
      while (shaped_pending.size() != 0) @(posedge clk_i);
    end
  endtask

  // Result checker with a randomly stalling receiver.
  initial begin
    shaped_t want;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (shaped_pending.size() == 0) begin
          errors++;
          $display("%0t: unexpected result sample_out=%h envelope=%h", $realtime,
                   out_if.sample_out, out_if.envelope);
        end else begin
          want = shaped_pending.pop_front();
          if (out_if.sample_out !== want.sample) begin
            errors++;
            $display("%0t: sample_out expected %h actual %h", $realtime, want.sample,
                     out_if.sample_out);
          end
          if (out_if.envelope !== want.env) begin
            errors++;
            $display("%0t: envelope expected %h actual %h", $realtime, want.env,
                     out_if.envelope);
          end
        end
      end
      out_if.ready <= (!stall_enable || $urandom_range(0, 3) != 0);
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 600000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    results_seen = 0;
    items_sent = 0;
    stall_enable = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    pressure_q = 17'd0;
    attack_q = 16'd328;
    release_q = 16'd7;
    level_q = '0;
    make_tanh_ref();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random();
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d sample items and checked %0d results.", items_sent, results_seen);
    $display("Pressure spanned pass-through, knee and clamped range with varied follower rates.");
    if (errors == 0 && shaped_pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pws_pkg.sv
hdl/pws_if.sv
hdl/pws_mac.sv
hdl/pressure_waveshaper_with_follower.sv
hdl/pws_checker.sv
verif/tb_pressure_waveshaper_with_follower.sv
